/* hw/rtl/sfot_pkg.sv */
// Shared constants and helper functions for the segment fan occlusion test.
// Used by the triangle unit, the multiplier chain and the top level.
// No dependencies.
`default_nettype none

package sfot_pkg;

	// Configuration register indexes.
	localparam int REG_INDEX_W = 3;
	localparam logic [REG_INDEX_W-1:0] REG_ORIGIN_X  = 3'd0;
	localparam logic [REG_INDEX_W-1:0] REG_ORIGIN_Y  = 3'd1;
	localparam logic [REG_INDEX_W-1:0] REG_BOX_MIN_X = 3'd2;
	localparam logic [REG_INDEX_W-1:0] REG_BOX_MIN_Y = 3'd3;
	localparam logic [REG_INDEX_W-1:0] REG_BOX_MAX_X = 3'd4;
	localparam logic [REG_INDEX_W-1:0] REG_BOX_MAX_Y = 3'd5;

	// Widest digit handled by one multiplier cell.
	localparam int MUL_DIGIT_MAX = 27;

	// Register stages of the triangle unit outside its multiplier chains.
	localparam int TRI_FIXED_STAGES = 7;

	// Width of the clip numerators and denominators for a coordinate width.
	function automatic int num_width(input int cw);
		return 2 * cw + 14;
	endfunction

	// Number of digits an operand of width w is cut into.
	function automatic int mul_digits(input int w);
		return (w + MUL_DIGIT_MAX - 1) / MUL_DIGIT_MAX;
	endfunction

	// Number of cells of a multiplier chain for width w.
	function automatic int mul_depth(input int w);
		return mul_digits(w) * mul_digits(w);
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/sfot_mul_cell.sv */
// One cell of the digit-serial multiplier chain: one digit product per cycle while en is high.
// Stand-alone; instantiated by sfot_mul_chain.
`default_nettype none

module sfot_mul_cell #(
	parameter int AW  = 78,
	parameter int DGW = 26,
	parameter int DI  = 0,
	parameter int DJ  = 0
) (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic [AW-1:0]     a_in,
	input  wire logic [AW-1:0]     b_in,
	input  wire logic [2*AW-1:0]   acc_in,
	output logic      [AW-1:0]     a_q,
	output logic      [AW-1:0]     b_q,
	output logic      [2*AW-1:0]   acc_q
);

	logic [2*DGW-1:0] prod;

	// Digit product of this cell's digit pair.
	assign prod = a_in[DI*DGW +: DGW] * b_in[DJ*DGW +: DGW];

	// Add the weighted digit product and hand the operands to the next cell.
	always_ff @(posedge clk) begin
		if (en) begin
			a_q   <= a_in;
			b_q   <= b_in;
			acc_q <= acc_in + ((2*AW)'(prod) << ((DI + DJ) * DGW));
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/sfot_mul_chain.sv */
// Unsigned wide multiplier built as a row of digit cells, one product per cell.
// Depends on sfot_pkg and sfot_mul_cell.
`default_nettype none

module sfot_mul_chain #(
	parameter int W = 78
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [W-1:0]     a,
	input  wire logic [W-1:0]     b,
	output logic      [2*W-1:0]   p
);

	localparam int NDIG = sfot_pkg::mul_digits(W);
	localparam int DGW  = (W + NDIG - 1) / NDIG;
	localparam int AW   = NDIG * DGW;
	localparam int NC   = NDIG * NDIG;

	logic [AW-1:0]   a_w   [NC+1];
	logic [AW-1:0]   b_w   [NC+1];
	logic [2*AW-1:0] acc_w [NC+1];

	assign a_w[0]   = AW'(a);
	assign b_w[0]   = AW'(b);
	assign acc_w[0] = '0;

	// One cell per digit pair; the sum travels down the row.
	for (genvar k = 0; k < NC; k++) begin : g_cell
		sfot_mul_cell #(
			.AW (AW),
			.DGW(DGW),
			.DI (k / NDIG),
			.DJ (k % NDIG)
		) u_cell (
			.clk   (clk),
			.en    (en),
			.a_in  (a_w[k]),
			.b_in  (b_w[k]),
			.acc_in(acc_w[k]),
			.a_q   (a_w[k+1]),
			.b_q   (b_w[k+1]),
			.acc_q (acc_w[k+1])
		);
	end

	assign p = acc_w[NC][2*W-1:0];

endmodule

`default_nettype wire

/* hw/rtl/sfot_tri.sv */
// Pipelined test of one wall segment against one closed triangle (origin and
// one box edge), with an epsilon on every side. Depends on sfot_pkg and
// sfot_mul_chain.
`default_nettype none

module sfot_tri #(
	parameter int COORD_WIDTH   = 32,
	parameter int FRACTION_BITS = 12
) (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic signed [COORD_WIDTH-1:0] ax,
	input  wire logic signed [COORD_WIDTH-1:0] ay,
	input  wire logic signed [COORD_WIDTH-1:0] bx,
	input  wire logic signed [COORD_WIDTH-1:0] by,
	input  wire logic signed [COORD_WIDTH-1:0] ox,
	input  wire logic signed [COORD_WIDTH-1:0] oy,
	input  wire logic signed [COORD_WIDTH-1:0] px,
	input  wire logic signed [COORD_WIDTH-1:0] py,
	input  wire logic signed [COORD_WIDTH-1:0] qx,
	input  wire logic signed [COORD_WIDTH-1:0] qy,
	output logic                               hit_q
);

	localparam int DW = COORD_WIDTH + 1;
	localparam int PW = 2 * DW;
	localparam int XW = PW + 1;
	localparam int GW = sfot_pkg::num_width(COORD_WIDTH);
	localparam int NC = sfot_pkg::mul_depth(GW);
	localparam int MW = 2 * GW;

	// Smallest triangle area (exact units) that still counts as a triangle.
	localparam longint AREA_MIN_L =
		((64'sd1 <<< (2 * FRACTION_BITS)) + 64'sd99999999) / 64'sd100000000;
	localparam logic signed [XW-1:0] AREA_MIN = XW'(AREA_MIN_L);
	localparam logic signed [GW-1:0] UNIT = GW'(64'sd1 <<< (2 * FRACTION_BITS));

	localparam int NXT [3] = '{1, 2, 0};
	localparam int PI  [3] = '{0, 0, 1};
	localparam int PJ  [3] = '{1, 2, 2};

	typedef struct packed {
		logic       degen;
		logic       any_empty;
		logic [2:0] lower;
		logic [2:0] upper;
	} tri_flags_t;

	// Scale a side distance by 1000 and add one square unit.
	function automatic logic signed [GW-1:0] side_margin(input logic signed [XW-1:0] x);
		logic signed [GW-1:0] w;
		w = GW'(x);
		return (w <<< 10) - (w <<< 4) - (w <<< 3) + UNIT;
	endfunction

	logic signed [COORD_WIDTH-1:0] vx [3];
	logic signed [COORD_WIDTH-1:0] vy [3];

	assign vx[0] = ox;
	assign vy[0] = oy;
	assign vx[1] = px;
	assign vy[1] = py;
	assign vx[2] = qx;
	assign vy[2] = qy;

	logic signed [DW-1:0] ex_s1 [3], ey_s1 [3];
	logic signed [DW-1:0] rax_s1 [3], ray_s1 [3], rbx_s1 [3], rby_s1 [3];
	logic signed [DW-1:0] qox_s1, qoy_s1;
	logic signed [PW-1:0] pa1_s2 [3], pa2_s2 [3], pb1_s2 [3], pb2_s2 [3];
	logic signed [PW-1:0] ar1_s2, ar2_s2;
	logic signed [XW-1:0] da_s3 [3], db_s3 [3];
	logic signed [XW-1:0] area_s3;
	logic signed [XW-1:0] da_s4 [3], db_s4 [3];
	logic                 degen_s4, degen_s5;
	logic signed [GW-1:0] ga_s5 [3], gb_s5 [3];
	logic        [GW-1:0] num_s6 [3], den_s6 [3];
	tri_flags_t           flags_s6;
	tri_flags_t           flags_line_q [NC];
	logic        [MW-1:0] prod_p [3], prod_q [3];
	logic        [2:0]    pair_ok;

	// Edge vectors and endpoint offsets from each triangle vertex.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int e = 0; e < 3; e++) begin
				ex_s1[e]  <= DW'(vx[NXT[e]]) - DW'(vx[e]);
				ey_s1[e]  <= DW'(vy[NXT[e]]) - DW'(vy[e]);
				rax_s1[e] <= DW'(ax) - DW'(vx[e]);
				ray_s1[e] <= DW'(ay) - DW'(vy[e]);
				rbx_s1[e] <= DW'(bx) - DW'(vx[e]);
				rby_s1[e] <= DW'(by) - DW'(vy[e]);
			end
			qox_s1 <= DW'(qx) - DW'(ox);
			qoy_s1 <= DW'(qy) - DW'(oy);
		end
	end

	// Cross product terms.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int e = 0; e < 3; e++) begin
				pa1_s2[e] <= ex_s1[e] * ray_s1[e];
				pa2_s2[e] <= ey_s1[e] * rax_s1[e];
				pb1_s2[e] <= ex_s1[e] * rby_s1[e];
				pb2_s2[e] <= ey_s1[e] * rbx_s1[e];
			end
			ar1_s2 <= ex_s1[0] * qoy_s1;
			ar2_s2 <= ey_s1[0] * qox_s1;
		end
	end

	// Side distances of both endpoints and the triangle area.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int e = 0; e < 3; e++) begin
				da_s3[e] <= XW'(pa1_s2[e]) - XW'(pa2_s2[e]);
				db_s3[e] <= XW'(pb1_s2[e]) - XW'(pb2_s2[e]);
			end
			area_s3 <= XW'(ar1_s2) - XW'(ar2_s2);
		end
	end

	// Orient distances so that inside is positive; flag near-zero areas.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int e = 0; e < 3; e++) begin
				da_s4[e] <= area_s3[XW-1] ? -da_s3[e] : da_s3[e];
				db_s4[e] <= area_s3[XW-1] ? -db_s3[e] : db_s3[e];
			end
			degen_s4 <= (area_s3 < AREA_MIN) && (area_s3 > -AREA_MIN);
		end
	end

	// Margins against the epsilon band: negative means outside.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int e = 0; e < 3; e++) begin
				ga_s5[e] <= side_margin(da_s4[e]);
				gb_s5[e] <= side_margin(db_s4[e]);
			end
			degen_s5 <= degen_s4;
		end
	end

	// Clip parameter of each edge as a positive fraction num / den.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int e = 0; e < 3; e++) begin
				if (ga_s5[e][GW-1]) begin
					num_s6[e] <= GW'(-(GW+1)'(ga_s5[e]));
					den_s6[e] <= GW'((GW+1)'(gb_s5[e]) - (GW+1)'(ga_s5[e]));
				end else begin
					num_s6[e] <= GW'(ga_s5[e]);
					den_s6[e] <= GW'((GW+1)'(ga_s5[e]) - (GW+1)'(gb_s5[e]));
				end
				flags_s6.lower[e] <= ga_s5[e][GW-1] && !gb_s5[e][GW-1];
				flags_s6.upper[e] <= gb_s5[e][GW-1] && !ga_s5[e][GW-1];
			end
			flags_s6.any_empty <= (ga_s5[0][GW-1] && gb_s5[0][GW-1]) ||
				(ga_s5[1][GW-1] && gb_s5[1][GW-1]) ||
				(ga_s5[2][GW-1] && gb_s5[2][GW-1]);
			flags_s6.degen <= degen_s5;
		end
	end

	function automatic logic flags_s6_line_lower(input int e);
		return flags_line_q[NC-1].lower[e];
	endfunction

	function automatic logic flags_s6_line_upper(input int e);
		return flags_line_q[NC-1].upper[e];
	endfunction

	// Cross products of the clip fractions for every pair of edges.
	for (genvar k = 0; k < 3; k++) begin : g_pair
		sfot_mul_chain #(.W(GW)) u_mul_p (
			.clk(clk),
			.en (en),
			.a  (num_s6[PI[k]]),
			.b  (den_s6[PJ[k]]),
			.p  (prod_p[k])
		);
		sfot_mul_chain #(.W(GW)) u_mul_q (
			.clk(clk),
			.en (en),
			.a  (num_s6[PJ[k]]),
			.b  (den_s6[PI[k]]),
			.p  (prod_q[k])
		);
		// An entry bound of one edge must not lie past the exit bound of the other.
		assign pair_ok[k] =
			(!(flags_s6_line_lower(PI[k]) && flags_s6_line_upper(PJ[k])) ||
				(prod_p[k] <= prod_q[k])) &&
			(!(flags_s6_line_lower(PJ[k]) && flags_s6_line_upper(PI[k])) ||
				(prod_q[k] <= prod_p[k]));
	end

	// Edge flags travel beside the multiplier chains.
	always_ff @(posedge clk) begin
		if (en) begin
			flags_line_q[0] <= flags_s6;
			for (int k = 1; k < NC; k++) begin
				flags_line_q[k] <= flags_line_q[k-1];
			end
		end
	end

	// The segment hits a nondegenerate triangle if all clip intervals overlap.
	always_ff @(posedge clk) begin
		if (en) begin
			hit_q <= !flags_line_q[NC-1].degen && !flags_line_q[NC-1].any_empty && (&pair_ok);
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/segment_fan_occlusion_test_top.sv */
// Top level of the segment fan occlusion test: configuration registers, wall
// input stage, four triangle units, sticky blocked flag and output register.
// Depends on sfot_pkg and sfot_tri.
//
// The block takes one wall item every cycle while in_stall is low. A wall goes
// through an input register, a triangle unit of 7 + D stages, where D is the
// number of digit cells in each clip multiplier chain (9 at the default 32-bit
// coordinates, so 16 stages), and the output register. Throughput stays one
// wall per cycle while the pipeline does not hold. The pipeline only holds
// when the output register still carries an unread result and the wall at the
// end of the pipeline also brings one. Configuration writes take effect at
// once and must only happen while no wall is in flight.
`default_nettype none

module segment_fan_occlusion_test_top #(
	parameter int COORD_WIDTH   = 32,
	parameter int FRACTION_BITS = 12
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    cfg_wr_en,
	input  wire logic [sfot_pkg::REG_INDEX_W-1:0]        cfg_index,
	input  wire logic [COORD_WIDTH-1:0]                  cfg_data,
	input  wire logic                                    in_valid,
	output logic                                         in_stall,
	input  wire logic signed [COORD_WIDTH-1:0]           wall_ax,
	input  wire logic signed [COORD_WIDTH-1:0]           wall_ay,
	input  wire logic signed [COORD_WIDTH-1:0]           wall_bx,
	input  wire logic signed [COORD_WIDTH-1:0]           wall_by,
	input  wire logic                                    last_wall,
	output logic                                         out_valid,
	input  wire logic                                    out_stall,
	output logic                                         clear,
	output logic                                         box_invalid
);

	localparam int GW  = sfot_pkg::num_width(COORD_WIDTH);
	localparam int LAT = sfot_pkg::TRI_FIXED_STAGES + sfot_pkg::mul_depth(GW);

	typedef struct packed {
		logic valid;
		logic last;
		logic skip;
	} side_t;

	logic signed [COORD_WIDTH-1:0] origin_x_q, origin_y_q;
	logic signed [COORD_WIDTH-1:0] box_min_x_q, box_min_y_q, box_max_x_q, box_max_y_q;
	logic signed [COORD_WIDTH-1:0] ax_s1, ay_s1, bx_s1, by_s1;
	logic                          valid_s1, last_s1;
	logic signed [COORD_WIDTH-1:0] fx0, fy0, fx1, fy1, wx0, wy0, wx1, wy1;
	logic                          skip_s1;
	logic signed [COORD_WIDTH-1:0] cx [4], cy [4];
	logic        [3:0]             hit;
	side_t                         side_q [LAT];
	side_t                         fin;
	logic                          en, box_bad, wall_hit, blk_next;
	logic                          blocked_q, out_valid_q, clear_q, box_invalid_q;

	// Configuration register writes; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q  <= '0;
			origin_y_q  <= '0;
			box_min_x_q <= '0;
			box_min_y_q <= '0;
			box_max_x_q <= '0;
			box_max_y_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				sfot_pkg::REG_ORIGIN_X:  origin_x_q  <= cfg_data;
				sfot_pkg::REG_ORIGIN_Y:  origin_y_q  <= cfg_data;
				sfot_pkg::REG_BOX_MIN_X: box_min_x_q <= cfg_data;
				sfot_pkg::REG_BOX_MIN_Y: box_min_y_q <= cfg_data;
				sfot_pkg::REG_BOX_MAX_X: box_max_x_q <= cfg_data;
				sfot_pkg::REG_BOX_MAX_Y: box_max_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The pipeline holds only when a result would collide with an unread one.
	assign fin      = side_q[LAT-1];
	assign en       = !(out_valid_q && out_stall && fin.valid && fin.last);
	assign in_stall = !en;

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			ax_s1   <= wall_ax;
			ay_s1   <= wall_ay;
			bx_s1   <= wall_bx;
			by_s1   <= wall_by;
			last_s1 <= last_wall;
		end
	end

	// Skip walls with coincident endpoints or bounds that miss the view fan.
	always_comb begin
		fx0 = (box_min_x_q < origin_x_q) ? box_min_x_q : origin_x_q;
		fy0 = (box_min_y_q < origin_y_q) ? box_min_y_q : origin_y_q;
		fx1 = (box_max_x_q > origin_x_q) ? box_max_x_q : origin_x_q;
		fy1 = (box_max_y_q > origin_y_q) ? box_max_y_q : origin_y_q;
		wx0 = (ax_s1 < bx_s1) ? ax_s1 : bx_s1;
		wx1 = (ax_s1 < bx_s1) ? bx_s1 : ax_s1;
		wy0 = (ay_s1 < by_s1) ? ay_s1 : by_s1;
		wy1 = (ay_s1 < by_s1) ? by_s1 : ay_s1;
		skip_s1 = ((ax_s1 == bx_s1) && (ay_s1 == by_s1)) ||
			(fx0 > wx1) || (wx0 > fx1) || (fy0 > wy1) || (wy0 > fy1);
	end

	// Box corners in order around the box.
	assign cx[0] = box_min_x_q;
	assign cy[0] = box_min_y_q;
	assign cx[1] = box_max_x_q;
	assign cy[1] = box_min_y_q;
	assign cx[2] = box_max_x_q;
	assign cy[2] = box_max_y_q;
	assign cx[3] = box_min_x_q;
	assign cy[3] = box_max_y_q;

	// One triangle unit per box edge.
	for (genvar t = 0; t < 4; t++) begin : g_tri
		sfot_tri #(
			.COORD_WIDTH  (COORD_WIDTH),
			.FRACTION_BITS(FRACTION_BITS)
		) u_tri (
			.clk  (clk),
			.en   (en),
			.ax   (ax_s1),
			.ay   (ay_s1),
			.bx   (bx_s1),
			.by   (by_s1),
			.ox   (origin_x_q),
			.oy   (origin_y_q),
			.px   (cx[t]),
			.py   (cy[t]),
			.qx   (cx[(t + 1) % 4]),
			.qy   (cy[(t + 1) % 4]),
			.hit_q(hit[t])
		);
	end

	// Item control travels beside the triangle units.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LAT; k++) begin
				side_q[k] <= '0;
			end
		end else if (en) begin
			side_q[0] <= '{valid: valid_s1, last: last_s1, skip: skip_s1};
			for (int k = 1; k < LAT; k++) begin
				side_q[k] <= side_q[k-1];
			end
		end
	end

	// Sticky blocked flag and the result of the last wall.
	assign box_bad  = (box_max_x_q <= box_min_x_q) || (box_max_y_q <= box_min_y_q);
	assign wall_hit = !fin.skip && (|hit);
	assign blk_next = blocked_q || (!box_bad && wall_hit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blocked_q     <= 1'b0;
			out_valid_q   <= 1'b0;
			clear_q       <= 1'b0;
			box_invalid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (en && fin.valid) begin
				if (fin.last) begin
					out_valid_q   <= 1'b1;
					clear_q       <= !box_bad && !blk_next;
					box_invalid_q <= box_bad;
					blocked_q     <= 1'b0;
				end else begin
					blocked_q <= blk_next;
				end
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign clear       = clear_q;
	assign box_invalid = box_invalid_q;

	// The input only stalls behind an unread result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a waiting result");

	// A result always leaves the blocked flag cleared.
	a_flag_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(en && fin.valid && fin.last) |=> !blocked_q)
		else $error("blocked flag not cleared after a result");

	// An invalid box never reports a clear view.
	a_invalid_not_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(clear && box_invalid))
		else $error("clear reported for an invalid box");

	// A held pipeline keeps its end item in place.
	a_hold_end: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> (fin.valid && fin.last))
		else $error("end item lost while the pipeline held");

endmodule

`default_nettype wire
